### rtl/core/lpft_pkg.sv
package lpft_pkg;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned PROD_W   = COORD_W + COEF_W;
  localparam int unsigned ACC_W    = PROD_W + 4;
  localparam int unsigned SQ_W     = 2 * COORD_W - 1;
  localparam int unsigned RSQ_W    = 48;
  localparam int unsigned FRAC_W   = 14;
  localparam int unsigned CFG_DW   = 64;
  localparam int unsigned CFG_AW   = 6;

  localparam logic [7:0] RING_LIMIT = 8'd16;
  localparam logic [4:0] LINE_BASE  = 5'd4;
  localparam logic [15:0] INTEN_SAT = 16'd4080;
  localparam logic [7:0] REFL_MAX   = 8'd255;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [1:0] STATUS_EMIT     = 2'd0;
  localparam logic [1:0] STATUS_STALE    = 2'd1;
  localparam logic [1:0] STATUS_FILTERED = 2'd2;

  typedef enum logic [2:0] {
    REG_ROT_A    = 3'd0,
    REG_ROT_B    = 3'd1,
    REG_ROT_C    = 3'd2,
    REG_SHIFT_X  = 3'd3,
    REG_SHIFT_Y  = 3'd4,
    REG_SHIFT_Z  = 3'd5,
    REG_STRIDE   = 3'd6,
    REG_MIN_RSQ  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [63:0]               point_time;
    logic [63:0]               window_start;
    logic                      fuse_enable;
    logic [7:0]                ring_index;
    logic [7:0]                fire_grp;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [15:0]               intensity;
  } point_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [31:0]               time_offset;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [7:0]                reflectivity;
    logic [4:0]                line_number;
  } result_t;

  typedef struct packed {
    logic [47:0]               rot_a;
    logic [47:0]               rot_b;
    logic [47:0]               rot_c;
    logic signed [COORD_W-1:0] shift_x;
    logic signed [COORD_W-1:0] shift_y;
    logic signed [COORD_W-1:0] shift_z;
    logic [7:0]                stride;
    logic [RSQ_W-1:0]          min_range_sq;
  } cfg_t;

  // three restoring remainder steps, dividend bits msb first
  function automatic logic [7:0] rem_step3(input logic [7:0] rem_in,
                                           input logic [2:0] bits,
                                           input logic [7:0] dvs);
    logic [8:0] r;
    r = {1'b0, rem_in};
    for (int i = 2; i >= 0; i--) begin
      r = {r[7:0], bits[i]};
      if (r >= {1'b0, dvs}) begin
        r = r - {1'b0, dvs};
      end
    end
    return r[7:0];
  endfunction

endpackage

### rtl/core/lidar_point_filter_transform_top.sv
// Lidar point filter and rigid transform. One point is taken per clock (busy is
// always low) and its classified result appears on result with done high for a
// single cycle, after the point has passed the input register, the product stage,
// the row-sum stage and the output register.
// Every point yields exactly one result: status 0 carries the rotated and
// translated point, status 1 (stale) and 2 (filtered) carry zeros elsewhere.
// The receiver cannot stall, so it must take result on every cycle that done
// is high. Registers sit at 8-byte steps on the 64-bit APB port; the user must
// write them only while no point is in flight, which the block does not enforce.
module lidar_point_filter_transform_top
  import lpft_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  point_t            point,
  output logic              done,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t   cfg;
  logic   v1;
  point_t pt1;
  logic   group_ok;

  assign busy = 1'b0;

  lpft_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    pt1 <= point;
  end

  lpft_grp_chk u_grp_chk (
    .clk      (clk),
    .fire_grp (pt1.fire_grp),
    .stride   (cfg.stride),
    .group_ok (group_ok)
  );

  lpft_xform u_xform (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1),
    .pt       (pt1),
    .cfg      (cfg),
    .group_ok (group_ok),
    .done     (done),
    .result   (result)
  );

endmodule

### rtl/core/lpft_cfg.sv
module lpft_cfg
  import lpft_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot_a        <= 48'd16384;
      cfg.rot_b        <= 48'd1073741824;
      cfg.rot_c        <= 48'd70368744177664;
      cfg.shift_x      <= '0;
      cfg.shift_y      <= '0;
      cfg.shift_z      <= '0;
      cfg.stride       <= 8'd1;
      cfg.min_range_sq <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_ROT_A:   cfg.rot_a        <= pwdata[47:0];
        REG_ROT_B:   cfg.rot_b        <= pwdata[47:0];
        REG_ROT_C:   cfg.rot_c        <= pwdata[47:0];
        REG_SHIFT_X: cfg.shift_x      <= pwdata[COORD_W-1:0];
        REG_SHIFT_Y: cfg.shift_y      <= pwdata[COORD_W-1:0];
        REG_SHIFT_Z: cfg.shift_z      <= pwdata[COORD_W-1:0];
        REG_STRIDE:  cfg.stride       <= pwdata[7:0];
        REG_MIN_RSQ: cfg.min_range_sq <= pwdata[RSQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ROT_A:   prdata = CFG_DW'(cfg.rot_a);
      REG_ROT_B:   prdata = CFG_DW'(cfg.rot_b);
      REG_ROT_C:   prdata = CFG_DW'(cfg.rot_c);
      REG_SHIFT_X: prdata = CFG_DW'(cfg.shift_x[COORD_W-1:0]);
      REG_SHIFT_Y: prdata = CFG_DW'(cfg.shift_y[COORD_W-1:0]);
      REG_SHIFT_Z: prdata = CFG_DW'(cfg.shift_z[COORD_W-1:0]);
      REG_STRIDE:  prdata = CFG_DW'(cfg.stride);
      REG_MIN_RSQ: prdata = CFG_DW'(cfg.min_range_sq);
      default:     prdata = '0;
    endcase
  end

endmodule

### rtl/core/lpft_grp_chk.sv
module lpft_grp_chk
  import lpft_pkg::*;
(
  input  logic       clk,
  input  logic [7:0] fire_grp,
  input  logic [7:0] stride,
  output logic       group_ok
);

  // (group + 1) mod stride, three bits per stage, msb first
  logic [8:0] dvd;
  logic [7:0] dvs;
  logic [7:0] rem_a;
  logic [7:0] rem_b;
  logic [5:0] low_a;
  logic [2:0] low_b;
  logic [7:0] rem_c;

  assign dvd = {1'b0, fire_grp} + 9'd1;
  assign dvs = (stride == 8'd0) ? 8'd1 : stride;

  always_ff @(posedge clk) begin
    rem_a <= rem_step3(8'd0, dvd[8:6], dvs);
    low_a <= dvd[5:0];
    rem_b <= rem_step3(rem_a, low_a[5:3], dvs);
    low_b <= low_a[2:0];
  end

  assign rem_c    = rem_step3(rem_b, low_b, dvs);
  assign group_ok = (rem_c == 8'd0);

endmodule

### rtl/core/lpft_xform.sv
module lpft_xform
  import lpft_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  point_t  pt,
  input  cfg_t    cfg,
  input  logic    group_ok,
  output logic    done,
  output result_t result
);

  logic signed [COORD_W-1:0] crd [3];
  logic [47:0]               rows [3];
  logic signed [COORD_W-1:0] shifts [3];

  assign crd[0]    = pt.point_x;
  assign crd[1]    = pt.point_y;
  assign crd[2]    = pt.point_z;
  assign rows[0]   = cfg.rot_a;
  assign rows[1]   = cfg.rot_b;
  assign rows[2]   = cfg.rot_c;
  assign shifts[0] = cfg.shift_x;
  assign shifts[1] = cfg.shift_y;
  assign shifts[2] = cfg.shift_z;

  // stage 2: products, classification of the easy cases
  logic                     v2;
  logic                     stale2;
  logic                     ring_bad2;
  logic [31:0]              toff2;
  logic [7:0]               refl2;
  logic [4:0]               line2;
  logic signed [PROD_W-1:0] prod [3][3];
  logic [SQ_W-1:0]          sq [3];

  logic [63:0] tdiff;
  logic [16:0] inten_rnd;
  logic [7:0]  refl;

  assign tdiff     = pt.point_time - pt.window_start;
  assign inten_rnd = {1'b0, pt.intensity} + 17'd8;

  always_comb begin
    if (pt.intensity == 16'd0) begin
      refl = 8'd0;
    end else if (pt.intensity >= INTEN_SAT) begin
      refl = REFL_MAX;
    end else begin
      refl = inten_rnd[11:4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [2*COORD_W-1:0] s;
    stale2    <= !pt.fuse_enable || (pt.point_time < pt.window_start);
    ring_bad2 <= (pt.ring_index >= RING_LIMIT);
    toff2     <= tdiff[31:0];
    refl2     <= refl;
    line2     <= pt.ring_index[4:0] + LINE_BASE;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] <= $signed(rows[r][COEF_W*c +: COEF_W]) * crd[c];
      end
    end
    for (int c = 0; c < 3; c++) begin
      s = crd[c] * crd[c];
      sq[c] <= s[SQ_W-1:0];
    end
  end

  // stage 3: row sums and squared range
  logic                    v3;
  logic                    stale3;
  logic                    ring_bad3;
  logic [31:0]             toff3;
  logic [7:0]              refl3;
  logic [4:0]              line3;
  logic signed [ACC_W-1:0] acc [3];
  logic [RSQ_W-1:0]        rsq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    stale3    <= stale2;
    ring_bad3 <= ring_bad2;
    toff3     <= toff2;
    refl3     <= refl2;
    line3     <= line2;
    for (int r = 0; r < 3; r++) begin
      acc[r] <= ACC_W'(prod[r][0]) + ACC_W'(prod[r][1]) + ACC_W'(prod[r][2])
              + (ACC_W'(shifts[r]) <<< FRAC_W)
              + (ACC_W'(1) <<< (FRAC_W - 1));
    end
    rsq3 <= RSQ_W'(sq[0]) + RSQ_W'(sq[1]) + RSQ_W'(sq[2]);
  end

  // stage 4: round, saturate, select status
  logic signed [ACC_W-FRAC_W-1:0] q [3];
  logic signed [COORD_W-1:0]      sat [3];
  logic                           filt;
  result_t                        res_next;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      q[r] = (ACC_W-FRAC_W)'(acc[r] >>> FRAC_W);
      if (q[r] > (ACC_W-FRAC_W)'(COORD_MAX)) begin
        sat[r] = COORD_MAX;
      end else if (q[r] < (ACC_W-FRAC_W)'(COORD_MIN)) begin
        sat[r] = COORD_MIN;
      end else begin
        sat[r] = q[r][COORD_W-1:0];
      end
    end
  end

  assign filt = ring_bad3 || !group_ok || (rsq3 < cfg.min_range_sq);

  always_comb begin
    res_next = '0;
    if (stale3) begin
      res_next.status = STATUS_STALE;
    end else if (filt) begin
      res_next.status = STATUS_FILTERED;
    end else begin
      res_next.status       = STATUS_EMIT;
      res_next.time_offset  = toff3;
      res_next.out_x        = sat[0];
      res_next.out_y        = sat[1];
      res_next.out_z        = sat[2];
      res_next.reflectivity = refl3;
      res_next.line_number  = line3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule
